>>> src/tbcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbcs_pkg
// Shared types and constants for the tagged block comment scanner.
// ----------------------------------------------------------------------------
package tbcs_pkg;

    localparam int MAX_TAG = 30;
    localparam int WIN_LEN = MAX_TAG + 2;
    localparam int LEN_W   = $clog2(MAX_TAG + 1);
    localparam int CP_W    = 21;
    localparam int EV_W    = 3;

    typedef logic [CP_W-1:0]  cp_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [EV_W-1:0]  ev_t;

    localparam cp_t CP_HASH   = cp_t'(8'h23);
    localparam cp_t CP_LBRACE = cp_t'(8'h7B);
    localparam cp_t CP_RBRACE = cp_t'(8'h7D);
    localparam cp_t CP_SPACE  = cp_t'(8'h20);
    localparam cp_t CP_TAB    = cp_t'(8'h09);
    localparam cp_t CP_CR     = cp_t'(8'h0D);

    localparam ev_t EV_NONE  = 3'd0;
    localparam ev_t EV_START = 3'd1;
    localparam ev_t EV_TAG   = 3'd2;
    localparam ev_t EV_END   = 3'd3;
    localparam ev_t EV_UNFIN = 3'd4;
    localparam ev_t EV_NOTC  = 3'd5;

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_BRACE = 3'd1;
    localparam logic [2:0] PH_TAG   = 3'd2;
    localparam logic [2:0] PH_SKIP  = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;

    // per-beat strobes broadcast along the cell row
    typedef struct packed {
        logic start;      // comment opened: reload fixed cells, drop tag
        logic tag_shift;  // new tag char enters at the first tag cell
        logic win_shift;  // body char enters window at cell 0
    } tbcs_ctrl_t;

endpackage

>>> src/tbcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbcs_cell
// One window position: holds a body char, the expected pattern char and an
// active flag; compares the incoming body char against its pattern.
// ----------------------------------------------------------------------------
module tbcs_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tbcs_pkg::tbcs_ctrl_t ctrl,
    input  logic                fixed,    // holds a closing-delimiter char
    input  tbcs_pkg::cp_t       pat_in,
    input  logic                act_in,
    input  tbcs_pkg::cp_t       win_in,
    output tbcs_pkg::cp_t       pat_out,
    output logic                act_out,
    output tbcs_pkg::cp_t       win_out,
    output logic                hit
);
    import tbcs_pkg::*;

    cp_t  win_reg;
    cp_t  pat_reg;
    logic act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            act_reg <= fixed;
        end
        else if (ctrl.tag_shift && !fixed)
        begin
            act_reg <= act_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((ctrl.start && fixed) || (ctrl.tag_shift && !fixed))
        begin
            pat_reg <= pat_in;
        end
        if (ctrl.win_shift)
        begin
            win_reg <= win_in;
        end
    end

    assign hit     = !act_reg || (win_in == pat_reg);
    assign pat_out = pat_reg;
    assign act_out = act_reg;
    assign win_out = win_reg;

endmodule

>>> src/tagged_block_comment_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_block_comment_scanner_unit
// Scans a code point stream for tagged block comments with a row of
// window/pattern cells; one event beat per input beat.
// ----------------------------------------------------------------------------
// Output: the result beat is registered in the cycle after its input beat is accepted.
// Throughput: 1 beat per cycle unless a held result waits on m_tready; the window compare (one
// comparator per cell plus an AND across the row) settles within that cycle.
// Reset: rst_n async low; back to waiting, tag length zero, no result held.
// Window contents are cleared at the start of every comment body.
module tagged_block_comment_scanner_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        s_tlast,   // end_of_input
    input  logic        s_tuser,   // [0] start_allowed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [2:0] event_res, [7:3] tag_count
);
    import tbcs_pkg::*;

    logic [2:0] phase_reg, phase_next;
    len_t       tag_len_reg, tag_len_next;
    logic       out_valid_reg;
    ev_t        out_event_reg;
    len_t       out_count_reg;

    ev_t        ev;
    len_t       cnt;
    tbcs_ctrl_t ctrl_raw, ctrl;
    logic       win_clear;
    logic       acc;
    logic       eoi, allow, ws, match;
    cp_t        c;

    cp_t  win_in  [WIN_LEN];
    cp_t  win_out [WIN_LEN];
    cp_t  pat_in  [WIN_LEN];
    cp_t  pat_out [WIN_LEN];
    logic act_in  [WIN_LEN];
    logic act_out [WIN_LEN];
    logic [WIN_LEN-1:0] hit;

    assign c     = s_tdata[CP_W-1:0];
    assign eoi   = s_tlast;
    assign allow = s_tuser;
    assign ws    = (c == CP_SPACE) || ((c >= CP_TAB) && (c <= CP_CR));

    assign s_tready = !out_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;
    assign match    = &hit;

    always_comb
    begin
        phase_next   = phase_reg;
        tag_len_next = tag_len_reg;
        ev           = EV_NONE;
        cnt          = '0;
        ctrl_raw     = '0;
        win_clear    = 1'b0;
        case (phase_reg)
            PH_WAIT:
            begin
                if (!eoi && allow && (c == CP_LBRACE))
                begin
                    phase_next = PH_BRACE;
                end
            end
            PH_BRACE:
            begin
                if (!eoi && (c == CP_HASH))
                begin
                    ev             = EV_START;
                    tag_len_next   = '0;
                    phase_next     = PH_TAG;
                    ctrl_raw.start = 1'b1;
                end
                else
                begin
                    ev         = EV_NOTC;
                    phase_next = PH_WAIT;
                end
            end
            PH_TAG:
            begin
                if (eoi || ws)
                begin
                    if (tag_len_reg != '0)
                    begin
                        ev         = EV_TAG;
                        cnt        = tag_len_reg;
                        phase_next = PH_SKIP;
                    end
                    else if (eoi)
                    begin
                        ev         = EV_UNFIN;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        // empty tag: this whitespace is the first body char
                        win_clear          = 1'b1;
                        ctrl_raw.win_shift = 1'b1;
                        phase_next         = PH_BODY;
                        if (match)
                        begin
                            ev         = EV_END;
                            phase_next = PH_WAIT;
                        end
                    end
                end
                else
                begin
                    ctrl_raw.tag_shift = 1'b1;
                    tag_len_next       = tag_len_reg + len_t'(1);
                    if (tag_len_next >= len_t'(MAX_TAG))
                    begin
                        ev         = EV_TAG;
                        cnt        = tag_len_next;
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (eoi)
                begin
                    ev         = EV_UNFIN;
                    phase_next = PH_WAIT;
                end
                else if (!ws)
                begin
                    win_clear          = 1'b1;
                    ctrl_raw.win_shift = 1'b1;
                    phase_next         = PH_BODY;
                    if (match)
                    begin
                        ev         = EV_END;
                        phase_next = PH_WAIT;
                    end
                end
            end
            PH_BODY:
            begin
                if (eoi)
                begin
                    ev         = EV_UNFIN;
                    phase_next = PH_WAIT;
                end
                else
                begin
                    ctrl_raw.win_shift = 1'b1;
                    if (match)
                    begin
                        ev         = EV_END;
                        phase_next = PH_WAIT;
                    end
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    assign ctrl = acc ? ctrl_raw : '0;

    // cell 0 sees the newest char; pattern runs back from "}" "#" then the
    // tag, newest tag char first
    always_comb
    begin
        for (int k = 0; k < WIN_LEN; k++)
        begin
            if (k == 0)
            begin
                win_in[k] = c;
                pat_in[k] = CP_RBRACE;
                act_in[k] = 1'b1;
            end
            else if (k == 1)
            begin
                win_in[k] = win_clear ? '0 : win_out[k-1];
                pat_in[k] = CP_HASH;
                act_in[k] = 1'b1;
            end
            else if (k == 2)
            begin
                win_in[k] = win_clear ? '0 : win_out[k-1];
                pat_in[k] = c;
                act_in[k] = 1'b1;
            end
            else
            begin
                win_in[k] = win_clear ? '0 : win_out[k-1];
                pat_in[k] = pat_out[k-1];
                act_in[k] = act_out[k-1];
            end
        end
    end

    for (genvar g = 0; g < WIN_LEN; g++)
    begin : g_cell
        tbcs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .fixed   ((g < 2) ? 1'b1 : 1'b0),
            .pat_in  (pat_in[g]),
            .act_in  (act_in[g]),
            .win_in  (win_in[g]),
            .pat_out (pat_out[g]),
            .act_out (act_out[g]),
            .win_out (win_out[g]),
            .hit     (hit[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            tag_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                phase_reg   <= phase_next;
                tag_len_reg <= tag_len_next;
            end
            if (acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            out_event_reg <= ev;
            out_count_reg <= cnt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_event_reg};

endmodule
